@@ hdl/lpr_pkg.sv @@
// Shared types and constants for the panel ripple wavefront block.
package lpr_pkg;

   localparam int PANEL_COUNT     = 10;
   localparam int NEIGHBOUR_COUNT = 3;
   localparam int PANEL_IDX_W     = $clog2(PANEL_COUNT);
   localparam int ID_W            = 4;
   localparam int SLOT_W          = 3 * ID_W;
   localparam int ADJ_W           = 60;
   localparam int LEVEL_W         = 8;
   localparam int TIME_W          = 32;
   localparam int ROLL_W          = 16;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 60;

   localparam logic [ID_W-1:0] NO_NEIGHBOUR = 4'hF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ADJ_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADJ_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_STEP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_WAIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WAIT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd7;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [ID_W-1:0]   seed_panel;
      logic [ROLL_W-1:0] roll;
   } req_data_type;

   typedef struct packed {
      logic [ID_W-1:0]    panel_id;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } rsp_data_type;

   typedef struct packed {
      logic [TIME_W-1:0] min_wait_ms;
      logic [TIME_W-1:0] max_wait_ms;
      logic [ROLL_W-1:0] chance_threshold;
   } trig_cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak_level;
      logic [LEVEL_W-1:0] floor_level;
      logic [LEVEL_W-1:0] dim_step;
   } level_cfg_type;

endpackage

@@ hdl/lpr_panel_unit.sv @@
// Shared per-panel unit: wavefront lighting, dimming and neighbour decode.
module lpr_panel_unit (
   input  logic [lpr_pkg::LEVEL_W-1:0]     level_cur,
   input  logic                            front_bit,
   input  logic [lpr_pkg::SLOT_W-1:0]      adj_slot,
   input  lpr_pkg::level_cfg_type          level_cfg,
   output logic [lpr_pkg::LEVEL_W-1:0]     level_new,
   output logic [lpr_pkg::PANEL_COUNT-1:0] neighbour_mask
);

   logic [lpr_pkg::LEVEL_W-1:0] lit_level;

   always_comb begin
      lit_level = front_bit ? level_cfg.peak_level : level_cur;
      level_new = lit_level;
      if (lit_level > level_cfg.floor_level) begin
         level_new = (lit_level > level_cfg.dim_step) ?
                     lit_level - level_cfg.dim_step : '0;
      end
   end

   always_comb begin
      logic [lpr_pkg::ID_W-1:0] id;
      neighbour_mask = '0;
      for (int i = 0; i < lpr_pkg::NEIGHBOUR_COUNT; i++) begin
         id = adj_slot[i*lpr_pkg::ID_W +: lpr_pkg::ID_W];
         for (int q = 0; q < lpr_pkg::PANEL_COUNT; q++) begin
            if (id != lpr_pkg::NO_NEIGHBOUR && id == lpr_pkg::ID_W'(q)) begin
               neighbour_mask[q] = 1'b1;
            end
         end
      end
   end

endmodule

@@ hdl/lpr_trigger.sv @@
// Ripple start decision: registered elapsed time, then the frontier, wait, chance and seed tests.
module lpr_trigger (
   input  logic                          clock,
   input  logic                          load_wait,
   input  logic [lpr_pkg::TIME_W-1:0]    now_ms,
   input  logic [lpr_pkg::TIME_W-1:0]    last_ripple_ms,
   input  logic [lpr_pkg::ID_W-1:0]      seed_panel,
   input  logic [lpr_pkg::ROLL_W-1:0]    roll,
   input  logic                          front_empty,
   input  lpr_pkg::trig_cfg_type         trig_cfg,
   output logic                          start
);

   logic [lpr_pkg::TIME_W-1:0] wait_ff;
   logic [lpr_pkg::TIME_W-1:0] wait_in;

   // modulo 2^32 difference
   assign wait_in = load_wait ? now_ms - last_ripple_ms : wait_ff;

   always_ff @(posedge clock) begin
      wait_ff <= wait_in;
   end

   assign start = front_empty
                  && (wait_ff > trig_cfg.min_wait_ms)
                  && ((wait_ff > trig_cfg.max_wait_ms) || (roll < trig_cfg.chance_threshold))
                  && (seed_panel < lpr_pkg::ID_W'(lpr_pkg::PANEL_COUNT));

endmodule

@@ hdl/led_panel_ripple_wavefront_core.sv @@
// A request enters WALK in the cycle after it is taken; the shared panel unit then handles
// one panel per cycle for ten panels while the output does not stall. State FRONT forms the
// new frontier and elapsed time, state DECIDE decides a ripple start. No new request is
// taken until the block is back in IDLE. Output stall lengthens the walk.
// Reset is synchronous: sets, levels and last ripple time clear, registers take defaults.
module led_panel_ripple_wavefront_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lpr_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lpr_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_we,
   input  logic [lpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FRONT  = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   localparam int PC = lpr_pkg::PANEL_COUNT;
   localparam int IW = lpr_pkg::PANEL_IDX_W;

   // configuration
   logic [lpr_pkg::ADJ_W-1:0]   adj_low_ff, adj_high_ff;
   lpr_pkg::level_cfg_type      level_cfg_ff;
   lpr_pkg::trig_cfg_type       trig_cfg_ff;

   // control and state
   logic [1:0]                  state_ff, state_in;
   logic [IW-1:0]               cnt_ff, cnt_in;
   logic [PC-1:0]               front_ff, front_in;
   logic [PC-1:0]               seen_ff, seen_in;
   logic [PC-1:0]               next_ff, next_in;
   logic [lpr_pkg::TIME_W-1:0]  last_ms_ff, last_ms_in;
   logic [lpr_pkg::LEVEL_W-1:0] level_ff [PC];
   logic                        rsp_valid_ff, rsp_valid_in;
   lpr_pkg::rsp_data_type       rsp_data_ff, rsp_data_in;
   lpr_pkg::req_data_type       item_ff, item_in;

   logic                        req_take, rsp_take, step;
   logic [lpr_pkg::LEVEL_W-1:0] level_new;
   logic [PC-1:0]               nb_mask;
   logic [2*lpr_pkg::ADJ_W-1:0] adj_all;
   logic [lpr_pkg::SLOT_W-1:0]  adj_slot;
   logic                        start;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign step      = (state_ff == S_WALK) && (!rsp_valid_ff || !rsp_stall);

   assign adj_all  = {adj_high_ff, adj_low_ff};
   assign adj_slot = adj_all[cnt_ff*lpr_pkg::SLOT_W +: lpr_pkg::SLOT_W];

   lpr_panel_unit u_panel (
      .level_cur      (level_ff[cnt_ff]),
      .front_bit      (front_ff[cnt_ff]),
      .adj_slot       (adj_slot),
      .level_cfg      (level_cfg_ff),
      .level_new      (level_new),
      .neighbour_mask (nb_mask)
   );

   lpr_trigger u_trigger (
      .clock          (clock),
      .load_wait      (state_ff == S_FRONT),
      .now_ms         (item_ff.now_ms),
      .last_ripple_ms (last_ms_ff),
      .seed_panel     (item_ff.seed_panel),
      .roll           (item_ff.roll),
      .front_empty    (front_ff == '0),
      .trig_cfg       (trig_cfg_ff),
      .start          (start)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      front_in     = front_ff;
      seen_in      = seen_ff;
      next_in      = next_ff;
      last_ms_in   = last_ms_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_data;
               cnt_in   = '0;
               next_in  = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (step) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.panel_id = lpr_pkg::ID_W'(cnt_ff);
               rsp_data_in.level    = level_new;
               rsp_data_in.last     = (cnt_ff == IW'(PC - 1));
               if (front_ff[cnt_ff]) begin
                  seen_in[cnt_ff] = 1'b1;
                  next_in         = next_ff | nb_mask;
               end
               if (cnt_ff == IW'(PC - 1)) begin
                  state_in = S_FRONT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_FRONT: begin
            front_in = next_ff & ~seen_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (start) begin
               front_in   = PC'(1) << item_ff.seed_panel;
               seen_in    = '0;
               last_ms_in = item_ff.now_ms;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         front_ff     <= '0;
         seen_ff      <= '0;
         next_ff      <= '0;
         last_ms_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < PC; p++) begin
            level_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         front_ff     <= front_in;
         seen_ff      <= seen_in;
         next_ff      <= next_in;
         last_ms_ff   <= last_ms_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            level_ff[cnt_ff] <= level_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         adj_low_ff                    <= {lpr_pkg::ADJ_W{1'b1}};
         adj_high_ff                   <= {lpr_pkg::ADJ_W{1'b1}};
         level_cfg_ff.peak_level       <= 8'd250;
         level_cfg_ff.floor_level      <= 8'd200;
         level_cfg_ff.dim_step         <= 8'd5;
         trig_cfg_ff.min_wait_ms       <= 32'd5000;
         trig_cfg_ff.max_wait_ms       <= 32'd15000;
         trig_cfg_ff.chance_threshold  <= 16'd218;
      end else if (csr_we) begin
         case (csr_index)
            lpr_pkg::REG_ADJ_LOW:   adj_low_ff  <= csr_wdata[lpr_pkg::ADJ_W-1:0];
            lpr_pkg::REG_ADJ_HIGH:  adj_high_ff <= csr_wdata[lpr_pkg::ADJ_W-1:0];
            lpr_pkg::REG_PEAK:      level_cfg_ff.peak_level  <= csr_wdata[7:0];
            lpr_pkg::REG_FLOOR:     level_cfg_ff.floor_level <= csr_wdata[7:0];
            lpr_pkg::REG_DIM_STEP:  level_cfg_ff.dim_step    <= csr_wdata[7:0];
            lpr_pkg::REG_MIN_WAIT:  trig_cfg_ff.min_wait_ms  <= csr_wdata[31:0];
            lpr_pkg::REG_MAX_WAIT:  trig_cfg_ff.max_wait_ms  <= csr_wdata[31:0];
            lpr_pkg::REG_THRESHOLD: trig_cfg_ff.chance_threshold <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // in DECIDE the frontier holds no panel already reached by this ripple
   a_front_seen_disjoint: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> ((front_ff & seen_ff) == '0))
      else $error("frontier overlaps seen set");

   // a new ripple starts from exactly one panel
   a_seed_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && start) |=> $onehot(front_ff))
      else $error("ripple start frontier not one-hot");

   // an accepted request starts the walk at panel zero
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_WALK && cnt_ff == '0))
      else $error("walk did not start at panel zero");
`endif

endmodule

@@ tb/led_panel_ripple_wavefront_core_tb.sv @@
// Self-checking testbench for the panel ripple wavefront core.
`timescale 1ns / 1ps

module led_panel_ripple_wavefront_core_tb;
   import lpr_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int MAX_REPORTS   = 10;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_data_type   req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_data_type   rsp_data;
   logic           csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_ADJ_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   led_panel_ripple_wavefront_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // register shadows, reset values
   logic [ADJ_W-1:0]   adj_low_q  = {ADJ_W{1'b1}};
   logic [ADJ_W-1:0]   adj_high_q = {ADJ_W{1'b1}};
   logic [LEVEL_W-1:0] peak_q     = 8'd250;
   logic [LEVEL_W-1:0] floor_q    = 8'd200;
   logic [LEVEL_W-1:0] dim_q      = 8'd5;
   logic [TIME_W-1:0]  min_wait_q = 32'd5000;
   logic [TIME_W-1:0]  max_wait_q = 32'd15000;
   logic [ROLL_W-1:0]  thresh_q   = 16'd218;

   // predicted panel state
   logic [PANEL_COUNT-1:0] wave_front   = '0;
   logic [PANEL_COUNT-1:0] lit_seen     = '0;
   logic [LEVEL_W-1:0]     panel_levels [PANEL_COUNT];
   logic [TIME_W-1:0]      ripple_ms    = '0;

   rsp_data_type pending_levels[$];

   int tx_idle_pct  = 13;
   int rx_idle_pct  = 50;
   int failures     = 0;
   int ticks_sent   = 0;
   int results_seen = 0;
   int ripples      = 0;
   int reg_writes   = 0;
   logic [TIME_W-1:0] tick_ms = '0;

   initial begin
      for (int p = 0; p < PANEL_COUNT; p++) begin
         panel_levels[p] = '0;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rx_idle_pct);
   end

   function automatic logic [PANEL_COUNT-1:0] neighbours_of(input int p);
      logic [ADJ_W-1:0]       word;
      int                     base;
      logic [ID_W-1:0]        id;
      logic [PANEL_COUNT-1:0] mask;
      word = (p < 5) ? adj_low_q : adj_high_q;
      base = (p < 5) ? p : p - 5;
      mask = '0;
      for (int i = 0; i < NEIGHBOUR_COUNT; i++) begin
         id = word[base*SLOT_W + i*ID_W +: ID_W];
         if (id != NO_NEIGHBOUR && int'(id) < PANEL_COUNT) mask[id] = 1'b1;
      end
      return mask;
   endfunction

   // advance the panel state by one tick and queue the ten panel levels it yields
   task automatic advance_panels(input req_data_type item);
      logic [PANEL_COUNT-1:0] next;
      logic [TIME_W-1:0]      elapsed;
      logic [LEVEL_W-1:0]     lv;
      rsp_data_type           res;
      next = '0;
      if (wave_front != '0) begin
         for (int p = 0; p < PANEL_COUNT; p++) begin
            if (wave_front[p]) begin
               lit_seen[p]     = 1'b1;
               panel_levels[p] = peak_q;
               next            = next | neighbours_of(p);
            end
         end
         wave_front = next & ~lit_seen;
      end
      elapsed = item.now_ms - ripple_ms;
      if (wave_front == '0 && elapsed > min_wait_q &&
          (elapsed > max_wait_q || item.roll < thresh_q) &&
          int'(item.seed_panel) < PANEL_COUNT) begin
         wave_front = '0;
         wave_front[item.seed_panel] = 1'b1;
         lit_seen  = '0;
         ripple_ms = item.now_ms;
         ripples++;
      end
      for (int p = 0; p < PANEL_COUNT; p++) begin
         lv = panel_levels[p];
         if (lv > floor_q) lv = (lv > dim_q) ? lv - dim_q : '0;
         panel_levels[p] = lv;
         res.panel_id = p[ID_W-1:0];
         res.level    = lv;
         res.last     = (p == PANEL_COUNT - 1);
         pending_levels.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_levels.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result: panel %0d level %0d last %0b",
                        rsp_data.panel_id, rsp_data.level, rsp_data.last);
         end else begin
            if (rsp_data.panel_id != pending_levels[0].panel_id ||
                rsp_data.level != pending_levels[0].level ||
                rsp_data.last != pending_levels[0].last) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("mismatch: expected panel %0d level %0d last %0b, got %0d %0d %0b",
                           pending_levels[0].panel_id, pending_levels[0].level,
                           pending_levels[0].last, rsp_data.panel_id, rsp_data.level,
                           rsp_data.last);
            end
            void'(pending_levels.pop_front());
         end
      end
   end

   // valid is left high after acceptance; the next request or idle_sender moves it
   task automatic send_tick(input req_data_type item);
      @(negedge clock);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_panels(item);
      ticks_sent++;
   endtask

   task automatic tick(input logic [TIME_W-1:0] now, input logic [ID_W-1:0] seed,
                       input logic [ROLL_W-1:0] roll);
      req_data_type item;
      item.now_ms     = now;
      item.seed_panel = seed;
      item.roll       = roll;
      send_tick(item);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // block idle: nothing in flight and the frontier update after the last panel done
   task automatic quiesce();
      idle_sender();
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_ADJ_LOW:   adj_low_q  = value;
         REG_ADJ_HIGH:  adj_high_q = value;
         REG_PEAK:      peak_q     = value[LEVEL_W-1:0];
         REG_FLOOR:     floor_q    = value[LEVEL_W-1:0];
         REG_DIM_STEP:  dim_q      = value[LEVEL_W-1:0];
         REG_MIN_WAIT:  min_wait_q = value[TIME_W-1:0];
         REG_MAX_WAIT:  max_wait_q = value[TIME_W-1:0];
         REG_THRESHOLD: thresh_q   = value[ROLL_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // ring 0..9 with an out-of-range id in the third slot; panels 0-4 in the low word
   function automatic logic [2*ADJ_W-1:0] ring_graph();
      logic [2*ADJ_W-1:0] words;
      words = '0;
      for (int p = 0; p < PANEL_COUNT; p++) begin
         words[p*SLOT_W +: ID_W]          = ID_W'((p + 9) % 10);
         words[p*SLOT_W + ID_W +: ID_W]   = ID_W'((p + 1) % 10);
         words[p*SLOT_W + 2*ID_W +: ID_W] = ID_W'(10 + p % 6);
      end
      return words;
   endfunction

   function automatic logic [2*ADJ_W-1:0] random_graph();
      logic [2*ADJ_W-1:0] words;
      for (int s = 0; s < 3 * PANEL_COUNT; s++) begin
         if ($urandom_range(0, 19) < 14) words[s*ID_W +: ID_W] = ID_W'($urandom_range(0, 9));
         else                            words[s*ID_W +: ID_W] = ID_W'($urandom_range(10, 15));
      end
      return words;
   endfunction

   task automatic test_default_registers();
      tick(32'd0, 4'd0, 16'hFFFF);            // no wait yet
      tick(32'd15001, 4'd9, 16'hFFFF);        // past the maximum wait
      tick(32'd15002, 4'd3, 16'hFFFF);        // seed lit, isolated panel
      tick(32'd20003, 4'd0, 16'd0);           // early start on a low roll
      tick(32'd20004, 4'd15, 16'd0);
      tick(32'hFFFF_FFFF, 4'd12, 16'd0);      // seed out of range
   endtask

   task automatic test_ring_and_extremes();
      logic [2*ADJ_W-1:0] ring;
      quiesce();
      ring = ring_graph();
      write_reg(REG_ADJ_LOW, ring[ADJ_W-1:0]);
      write_reg(REG_ADJ_HIGH, ring[2*ADJ_W-1:ADJ_W]);
      write_reg(REG_PEAK, 60'd255);
      write_reg(REG_FLOOR, 60'd0);
      write_reg(REG_DIM_STEP, 60'd100);       // 255, 155, 55, then clamped to zero
      write_reg(REG_MIN_WAIT, 60'd0);
      write_reg(REG_MAX_WAIT, 60'd0);
      write_reg(REG_THRESHOLD, 60'd0);
      for (int n = 0; n < 8; n++) tick(32'd100 + n, (n == 7) ? 4'd15 : 4'(n), 16'd0);
      quiesce();
      write_reg(REG_PEAK, 60'd0);
      write_reg(REG_FLOOR, 60'd255);
      write_reg(REG_DIM_STEP, 60'd0);
      write_reg(REG_MIN_WAIT, 60'hFFFF_FFFF);
      write_reg(REG_MAX_WAIT, 60'hFFFF_FFFF);
      write_reg(REG_THRESHOLD, 60'hFFFF);
      tick(32'd0, 4'd5, 16'd0);
      tick(32'h8000_0000, 4'd9, 16'd0);
      tick(32'hFFFF_FFFF, 4'd0, 16'hFFFF);
      tick(32'h5555_AAAA, 4'd7, 16'h5A5A);
      quiesce();
      write_reg(REG_ADJ_LOW, 60'd0);          // every low panel points at panel 0
      write_reg(REG_ADJ_HIGH, {CSR_DATA_W{1'b1}});
      write_reg(REG_PEAK, 60'd128);
      write_reg(REG_FLOOR, 60'd127);
      write_reg(REG_DIM_STEP, 60'd255);
      write_reg(REG_MIN_WAIT, 60'd0);
      write_reg(REG_THRESHOLD, 60'hFFFF);
      tick(32'd10, 4'd4, 16'hFFFF);           // roll not below threshold
      tick(32'd11, 4'd4, 16'd0);
      tick(32'd12, 4'd2, 16'hFFFE);
      tick(32'd13, 4'd8, 16'd1);
   endtask

   task automatic test_random_ticks(input int tx_pct, input int rx_pct, input int count);
      logic [2*ADJ_W-1:0] graph;
      logic [LEVEL_W-1:0] peak;
      logic [TIME_W-1:0]  min_wait;
      req_data_type       item;
      int                 step_max;
      quiesce();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      graph    = random_graph();
      peak     = LEVEL_W'($urandom_range(100, 255));
      min_wait = TIME_W'($urandom_range(0, 60));
      step_max = $urandom_range(5, 40);
      write_reg(REG_ADJ_LOW, graph[ADJ_W-1:0]);
      write_reg(REG_ADJ_HIGH, graph[2*ADJ_W-1:ADJ_W]);
      write_reg(REG_PEAK, CSR_DATA_W'(peak));
      write_reg(REG_FLOOR, CSR_DATA_W'($urandom_range(0, peak)));
      write_reg(REG_DIM_STEP, CSR_DATA_W'($urandom_range(1, 40)));
      write_reg(REG_MIN_WAIT, CSR_DATA_W'(min_wait));
      write_reg(REG_MAX_WAIT, CSR_DATA_W'(min_wait + $urandom_range(0, 120)));
      write_reg(REG_THRESHOLD, CSR_DATA_W'($urandom_range(0, 65535)));
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) quiesce();       // hold off until all levels are back
         if ($urandom_range(0, 9) == 0) begin
            item.now_ms     = $urandom();
            item.seed_panel = ID_W'($urandom_range(0, 15));
         end else begin
            tick_ms         = tick_ms + TIME_W'($urandom_range(0, step_max));
            item.now_ms     = tick_ms;
            item.seed_panel = ID_W'($urandom_range(0, 9));
         end
         item.roll = ROLL_W'($urandom_range(0, 65535));
         send_tick(item);
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_ring_and_extremes();
      test_random_ticks(13, 50, 26);
      test_random_ticks(50, 13, 26);
      test_random_ticks(0, 0, 26);
      idle_sender();
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d ticks, %0d panel levels checked, %0d ripples started, %0d register writes",
               ticks_sent, results_seen, ripples, reg_writes);
      $display("%0d mismatching or unexpected levels", failures);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d levels outstanding", pending_levels.size());
      $display("simulation failed");
      $finish;
   end

endmodule
